[src/wpt_pkg.sv]
`default_nettype none

package wpt_pkg;

   localparam int unsigned DATA_WIDTH     = 32;
   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   typedef logic [DATA_WIDTH-1:0]     word_type;
   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;

   localparam csr_addr_type ADDR_FLOOR_VALUE = csr_addr_type'(0);

   typedef enum logic {
      WPT_IDLE,
      WPT_SCAN
   } wpt_state_type;

   function automatic word_type max_word(input word_type a, input word_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

[src/wpt_cell.sv]
`default_nettype none

module wpt_cell (
   input  wire              clock,
   input  wire              shift_en,
   input  wpt_pkg::word_type data_in,
   output wpt_pkg::word_type data_out,
   input  wpt_pkg::word_type acc_in,
   output wpt_pkg::word_type acc_out
);
   import wpt_pkg::*;

   word_type data_ff;
   word_type data_in_mux;
   word_type acc_ff;
   word_type acc_in_max;

   always_comb begin
      data_in_mux = shift_en ? data_in : data_ff;
      acc_in_max  = max_word(acc_in, data_ff);
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_mux;
      acc_ff  <= acc_in_max;
   end

   assign data_out = data_ff;
   assign acc_out  = acc_ff;

endmodule

`default_nettype wire

[src/windowed_peak_tracker_unit.sv]
`default_nettype none

// Channel    | Direction | Handshake            | Payload
// -----------+-----------+----------------------+------------------------
// req        | in        | req_valid/req_stall  | req_sample[31:0]
// rsp        | out       | rsp_valid/rsp_stall  | rsp_window_max[31:0]
// csr        | in/out    | APB, pready always 1 | floor_value at 0x0
//
// A result is normally computed directly from the request and then registered.
// When the evicted sample held the maximum, the chain of cells recomputes it
// through the running-max chain, which spans all WINDOW_DEPTH cells.
// Reset is synchronous and clears the fill count, the maximum and the floor.
// One finished result can wait while the next transaction is computed; the
// request side stalls while a second result would have nowhere to go.

module windowed_peak_tracker_unit #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wpt_pkg::word_type            req_sample,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output wpt_pkg::word_type            rsp_window_max,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wpt_pkg::csr_addr_type        csr_paddr,
   input  wire [wpt_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [wpt_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                         csr_pready
);
   import wpt_pkg::*;

   localparam int unsigned FILL_WIDTH = $clog2(WINDOW_DEPTH + 1);
   localparam logic [FILL_WIDTH-1:0] FILL_FULL = FILL_WIDTH'(WINDOW_DEPTH);

   word_type data_chain [WINDOW_DEPTH];
   word_type acc_chain  [WINDOW_DEPTH];

   wpt_state_type state_ff, state_in;
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;
   logic [FILL_WIDTH-1:0] scan_cnt_ff, scan_cnt_in;
   word_type cur_max_ff, cur_max_in;
   word_type floor_ff, floor_in;
   logic pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   word_type rsp_max_ff, rsp_max_in;

   logic req_accept;
   logic full;
   logic ge_max;
   logic need_scan;
   logic scan_done;
   logic result_ready;
   logic out_free;
   logic csr_write;
   word_type direct_max;
   word_type new_max;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         wpt_cell u_cell (
            .clock    (clock),
            .shift_en (req_accept),
            .data_in  (req_sample),
            .data_out (data_chain[i]),
            .acc_in   (floor_ff),
            .acc_out  (acc_chain[i])
         );
      end else begin : g_body
         wpt_cell u_cell (
            .clock    (clock),
            .shift_en (req_accept),
            .data_in  (data_chain[i-1]),
            .data_out (data_chain[i]),
            .acc_in   (acc_chain[i-1]),
            .acc_out  (acc_chain[i])
         );
      end
   end

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == ADDR_FLOOR_VALUE) ? floor_ff : '0;
   assign floor_in   = (csr_write && csr_paddr == ADDR_FLOOR_VALUE) ? csr_pwdata : floor_ff;

   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      fill_in      = fill_ff;
      cur_max_in   = cur_max_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;

      req_stall  = (state_ff != WPT_IDLE) || pend_ff;
      req_accept = req_valid && !req_stall;
      full       = (fill_ff == FILL_FULL);
      ge_max     = (req_sample >= cur_max_ff);
      need_scan  = !ge_max && full && (data_chain[WINDOW_DEPTH-1] >= cur_max_ff);
      direct_max = ge_max ? max_word(floor_ff, req_sample) : max_word(cur_max_ff, floor_ff);
      scan_done  = 1'b0;
      out_free   = !rsp_valid_ff || !rsp_stall;

      case (state_ff)
         WPT_IDLE: begin
            if (req_accept) begin
               if (!full) begin
                  fill_in = fill_ff + FILL_WIDTH'(1);
               end
               if (need_scan) begin
                  state_in    = WPT_SCAN;
                  scan_cnt_in = '0;
               end
            end
         end
         WPT_SCAN: begin
            scan_cnt_in = scan_cnt_ff + FILL_WIDTH'(1);
            if (scan_cnt_ff == FILL_FULL) begin
               scan_done = 1'b1;
               state_in  = WPT_IDLE;
            end
         end
         default: begin
            state_in = WPT_IDLE;
         end
      endcase

      result_ready = (req_accept && !need_scan) || scan_done;
      new_max      = scan_done ? acc_chain[WINDOW_DEPTH-1] : direct_max;

      if (result_ready) begin
         cur_max_in = new_max;
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_max_in   = new_max;
         end else begin
            pend_in = 1'b1;
         end
      end else if (pend_ff && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_max_in   = cur_max_ff;
         pend_in      = 1'b0;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WPT_IDLE;
         scan_cnt_ff  <= '0;
         fill_ff      <= '0;
         cur_max_ff   <= '0;
         floor_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         fill_ff      <= fill_in;
         cur_max_ff   <= cur_max_in;
         floor_ff     <= floor_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

   // A waiting result only exists behind a result that is being held.
   a_pend_needs_out: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> rsp_valid_ff)
      else $error("pending result without a held output");

   // A rescan only starts once the window is full.
   a_scan_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WPT_SCAN) |-> (fill_ff == FILL_FULL))
      else $error("rescan with a partial window");

   // An evicted maximum sends the block into a rescan unless the new sample reaches it.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && need_scan) |=> (state_ff == WPT_SCAN))
      else $error("evicted maximum did not start a rescan");

   // No new request is taken during a rescan.
   a_scan_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WPT_SCAN) |-> !req_accept)
      else $error("request accepted during a rescan");

endmodule

`default_nettype wire
